>>> sv/dwlc_pkg.sv
// ----------------------------------------------------------------------------
// dwlc_pkg
// Shared types and codes for the dry/wet latency crossfader.
// ----------------------------------------------------------------------------
package dwlc_pkg;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_COMMIT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [0:0] REG_ASSET_ACTIVE = 1'd0;
  localparam logic [0:0] REG_REPL_DRY     = 1'd1;

  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned LAT_W       = 17;
  localparam int unsigned MIX_FULL    = 128;
  // fade length in frames; 128*FADE_FRAMES must stay a power of two
  localparam int unsigned FADE_FRAMES = 128;

  typedef enum logic [1:0] {
    K_SAMPLE = 2'd0,
    K_COMMIT = 2'd1,
    K_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_MIX,
    B_MUL,
    B_DIVS,
    B_DIV,
    B_OUT
  } back_state_e;

  typedef struct packed {
    kind_e                       kind;
    logic [2:0]                  channel;
    logic signed [SAMPLE_W-1:0]  dry;
    logic signed [SAMPLE_W-1:0]  wet;
    logic                        frame_end;
    logic                        block_end;
    logic [LAT_W-1:0]            latency;
  } item_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_stat_t;

endpackage

>>> sv/dwlc_front.sv
// ----------------------------------------------------------------------------
// dwlc_front
// Accepts stream words, drops unknown commands and out-of-range channels,
// and queues the rest for the back end.
// ----------------------------------------------------------------------------
module dwlc_front #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [71:0]          in_data_i,
  input  logic                 in_last_i,
  input  logic [1:0]           in_user_i,
  input  dwlc_pkg::back_stat_t stat_i,
  output logic                 q_valid_o,
  output dwlc_pkg::item_t      q_item_o,
  input  logic                 q_pop_i
);
  import dwlc_pkg::*;

  item_t      fifo_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  item_t      item;
  logic       keep, push;

  always_comb begin
    item.channel   = in_data_i[2:0];
    item.dry       = in_data_i[26:3];
    item.wet       = in_data_i[50:27];
    item.block_end = in_data_i[51];
    item.latency   = in_data_i[68:52];
    item.frame_end = in_last_i;
    item.kind      = K_SAMPLE;
    keep           = 1'b0;
    case (in_user_i)
      CMD_SAMPLE: begin
        item.kind = K_SAMPLE;
        keep      = 32'(item.channel) < CHANNELS;
      end
      CMD_COMMIT: begin
        item.kind = K_COMMIT;
        keep      = 1'b1;
      end
      CMD_CLEAR: begin
        item.kind = K_CLEAR;
        keep      = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready_o = !stat_i.clearing && (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o && keep;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_item_o   = fifo_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !(q_pop_i && q_valid_o)) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i && q_valid_o) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= !wr_q;
      if (q_pop_i && q_valid_o) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= item;
  end

endmodule

>>> sv/dwlc_div.sv
// ----------------------------------------------------------------------------
// dwlc_div
// Divider by a power of two: registered right shift, quotient valid in the
// cycle after start.
// ----------------------------------------------------------------------------
module dwlc_div #(
  parameter int unsigned DVW = 41,
  parameter int unsigned SH  = 14,
  parameter int unsigned QW  = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  output logic           done_o,
  output logic [QW-1:0]  quot_o
);
  logic          done_q;
  logic [QW-1:0] quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) quot_q <= dividend_i[SH +: QW];
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> sv/dwlc_back.sv
// ----------------------------------------------------------------------------
// dwlc_back
// Executes queued words: latency commands, delay ring, wet-mix ramps,
// fade gain, rounding and saturation.
// ----------------------------------------------------------------------------
module dwlc_back #(
  parameter int unsigned DELAY_DEPTH = 131072,
  parameter int unsigned CHANNELS    = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  dwlc_pkg::item_t      q_item_i,
  output logic                 q_pop_o,
  input  logic                 asset_active_i,
  input  logic                 repl_dry_i,
  output dwlc_pkg::back_stat_t stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [23:0]          audio_o,
  output logic [2:0]           channel_o,
  output logic                 last_o,
  output logic                 dry_ready_o
);
  import dwlc_pkg::*;

  localparam int unsigned MEM_D = CHANNELS * DELAY_DEPTH;
  localparam int unsigned AW    = $clog2(MEM_D);
  localparam int unsigned PW    = $clog2(DELAY_DEPTH);
  localparam int unsigned FW    = $clog2(2 * FADE_FRAMES + 1);
  localparam int unsigned GW    = $clog2(FADE_FRAMES + 1);
  localparam int unsigned NW    = 32 + GW;
  localparam int unsigned DVW   = NW + 1;
  localparam int unsigned DEN   = 128 * FADE_FRAMES;

  back_state_e state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [PW-1:0]    wpos_q, wpos_d;
  logic [7:0]       mix_q [CHANNELS];
  logic [7:0]       mix_d [CHANNELS];
  logic [FW-1:0]    fade_q, fade_d;
  logic [LAT_W-1:0] cur_q, cur_d, prev_q, prev_d;
  logic             muted_q, muted_d, drdy_q, drdy_d;

  item_t            it_q, it_d;
  logic [GW-1:0]    gain_q, gain_d;
  logic [7:0]       mixv_q, mixv_d;
  logic             mute_q, mute_d, drout_q, drout_d, byp_q, byp_d;
  logic signed [31:0] v_q, v_d;
  logic signed [NW-1:0] num_q, num_d;

  logic [23:0]      mem [MEM_D];
  logic [23:0]      rd_q;
  logic             mem_we;
  logic [AW-1:0]    mem_wa, mem_ra;
  logic [23:0]      mem_wd;

  logic             ov_q, ov_d;
  logic [23:0]      aud_q, aud_d;
  logic [2:0]       ch_q, ch_d;
  logic             last_q, last_d, dro_q, dro_d;

  logic             div_start, div_done;
  logic [DVW-1:0]   dividend;
  logic [23:0]      quot;

  // per-item combinational helpers
  logic [PW-1:0]    delay, rpos;
  logic [PW:0]      rsum;
  logic [7:0]       target;
  logic             muted1, all_zero, all_full;
  logic [GW-1:0]    gain;
  logic signed [23:0] dsel;
  logic signed [24:0] aop;
  logic signed [33:0] prod;
  logic signed [GW:0] gs;
  logic [NW-1:0]    mag;
  logic [23:0]      qs;

  always_comb begin
    if (fade_q == '0) gain = GW'(FADE_FRAMES);
    else if (32'(fade_q) > FADE_FRAMES) gain = GW'(32'(fade_q) - FADE_FRAMES);
    else gain = GW'(FADE_FRAMES - 32'(fade_q));
  end

  dwlc_div #(.DVW(DVW), .SH($clog2(DEN)), .QW(24)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(dividend),
    .done_o(div_done), .quot_o(quot)
  );

  always_comb begin
    state_d = state_q;
    clr_d = clr_q; wpos_d = wpos_q; fade_d = fade_q;
    cur_d = cur_q; prev_d = prev_q; muted_d = muted_q; drdy_d = drdy_q;
    mix_d = mix_q;
    it_d = it_q; gain_d = gain_q; mixv_d = mixv_q; mute_d = mute_q;
    drout_d = drout_q; byp_d = byp_q; v_d = v_q; num_d = num_q;
    ov_d = ov_q && !out_ready_i;
    aud_d = aud_q; ch_d = ch_q; last_d = last_q; dro_d = dro_q;
    q_pop_o = 1'b0; mem_we = 1'b0; mem_wa = clr_q; mem_wd = '0; mem_ra = '0;
    div_start = 1'b0;
    delay = '0; rsum = '0; rpos = '0; target = '0; muted1 = muted_q;
    all_zero = 1'b1; all_full = 1'b1;
    dsel = '0; aop = '0; prod = '0; gs = '0; mag = '0; dividend = '0; qs = '0;

    case (state_q)
      B_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (32'(clr_q) == MEM_D - 1) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_item_i.kind)
            K_COMMIT: begin
              prev_d = cur_q;
              cur_d  = q_item_i.latency;
              fade_d = (cur_q == q_item_i.latency) ? '0 : FW'(2 * FADE_FRAMES);
              drdy_d = 1'b0;
            end
            K_CLEAR: begin
              prev_d  = cur_q;
              cur_d   = '0;
              fade_d  = (cur_q == '0) ? '0 : FW'(2 * FADE_FRAMES);
              muted_d = 1'b1;
              drdy_d  = 1'b0;
            end
            default: begin
              it_d    = q_item_i;
              state_d = B_READ;
            end
          endcase
        end
      end
      B_READ: begin
        muted1 = repl_dry_i ? 1'b1 : muted_q;
        drdy_d = repl_dry_i ? drdy_q : 1'b0;
        gain_d = gain;
        if (32'(fade_q) > FADE_FRAMES) begin
          delay = (32'(prev_q) >= DELAY_DEPTH) ? PW'(DELAY_DEPTH - 1) : PW'(prev_q);
        end else begin
          delay = (32'(cur_q) >= DELAY_DEPTH) ? PW'(DELAY_DEPTH - 1) : PW'(cur_q);
        end
        rsum = (wpos_q >= delay) ? ({1'b0, wpos_q} - {1'b0, delay})
                                 : ((PW + 1)'(DELAY_DEPTH) + {1'b0, wpos_q} - {1'b0, delay});
        rpos = rsum[PW-1:0];
        byp_d  = delay == '0;
        mem_we = 1'b1;
        mem_wa = AW'(it_q.channel) * AW'(DELAY_DEPTH) + AW'(wpos_q);
        mem_wd = it_q.dry;
        mem_ra = AW'(it_q.channel) * AW'(DELAY_DEPTH) + AW'(rpos);
        target = (asset_active_i && !repl_dry_i) ? 8'(MIX_FULL) : 8'd0;
        for (int i = 0; i < CHANNELS; i++) begin
          if (3'(i) == it_q.channel) begin
            if (mix_q[i] < target) mix_d[i] = mix_q[i] + 8'd1;
            else if (mix_q[i] > target) mix_d[i] = mix_q[i] - 8'd1;
          end
        end
        mixv_d = mix_d[it_q.channel];
        mute_d = muted1 || !asset_active_i;
        muted_d = muted1;
        if (it_q.frame_end) begin
          wpos_d = (32'(wpos_q) + 1 >= DELAY_DEPTH) ? '0 : wpos_q + PW'(1);
          if (fade_q != '0) fade_d = fade_q - FW'(1);
        end
        for (int i = 0; i < CHANNELS; i++) begin
          if (3'(i) <= it_q.channel) begin
            if (mix_d[i] != 8'd0) all_zero = 1'b0;
            if (mix_d[i] != 8'(MIX_FULL)) all_full = 1'b0;
          end
        end
        if (it_q.block_end) begin
          if (repl_dry_i && asset_active_i) drdy_d = all_zero;
          if (muted1 && !repl_dry_i && asset_active_i) muted_d = !all_full;
        end
        drout_d = drdy_d;
        state_d = B_MIX;
      end
      B_MIX: begin
        dsel = byp_q ? it_q.dry : $signed(rd_q);
        aop  = mute_q ? 25'(it_q.wet) : (25'(it_q.wet) - 25'(dsel));
        prod = aop * $signed({1'b0, mixv_q});
        v_d  = mute_q ? 32'(prod) : (32'(prod) + (32'(dsel) <<< 7));
        state_d = B_MUL;
      end
      B_MUL: begin
        gs      = {1'b0, gain_q};
        num_d   = v_q * gs;
        state_d = B_DIVS;
      end
      B_DIVS: begin
        mag       = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
        dividend  = DVW'(mag) + DVW'(DEN / 2);
        div_start = 1'b1;
        state_d   = B_DIV;
      end
      B_DIV: begin
        if (div_done) state_d = B_OUT;
      end
      B_OUT: begin
        if (!ov_q || out_ready_i) begin
          qs = (quot > 24'd8388608) ? 24'd8388608 : quot;
          if (num_q[NW-1]) aud_d = -qs;
          else aud_d = (qs > 24'd8388607) ? 24'd8388607 : qs;
          ch_d    = it_q.channel;
          last_d  = it_q.frame_end;
          dro_d   = drout_q;
          ov_d    = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
      wpos_q  <= '0;
      fade_q  <= '0;
      cur_q   <= '0;
      prev_q  <= '0;
      muted_q <= 1'b1;
      drdy_q  <= 1'b0;
      ov_q    <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) mix_q[i] <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      wpos_q  <= wpos_d;
      fade_q  <= fade_d;
      cur_q   <= cur_d;
      prev_q  <= prev_d;
      muted_q <= muted_d;
      drdy_q  <= drdy_d;
      ov_q    <= ov_d;
      mix_q   <= mix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q    <= it_d;
    gain_q  <= gain_d;
    mixv_q  <= mixv_d;
    mute_q  <= mute_d;
    drout_q <= drout_d;
    byp_q   <= byp_d;
    v_q     <= v_d;
    num_q   <= num_d;
    aud_q   <= aud_d;
    ch_q    <= ch_d;
    last_q  <= last_d;
    dro_q   <= dro_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[mem_ra];
  end

  assign stat_o.clearing = state_q == B_CLEAR;
  assign stat_o.busy     = state_q != B_IDLE;
  assign out_valid_o     = ov_q;
  assign audio_o         = aud_q;
  assign channel_o       = ch_q;
  assign last_o          = last_q;
  assign dry_ready_o     = dro_q;

endmodule

>>> sv/dry_wet_latency_crossfader_unit.sv
// ----------------------------------------------------------------------------
// dry_wet_latency_crossfader_unit
// Per-channel dry delay, wet-mix ramp and latency-change fade.
// ----------------------------------------------------------------------------
// channel  dir  carries
// s_axis   in   tdata: channel, dry_in, wet_in, block_end, new_latency;
//               tuser: cmd; tlast: frame_end
// m_axis   out  tdata: audio_out, channel_out, dry_ready; tlast: frame_last
// cfg      in   index 0 asset_active, 1 replacement_dry_request
//
// Sample word: back-end steps pop, ring access, mix, gain multiply, rounding
// shift start, shift and output load; the last waits on a full output.
// Command word: executed in the back end's idle state as it is popped.
// After reset the delay ring is zeroed while input is held.
// A two-word queue decouples input from execution; one output register.
// ----------------------------------------------------------------------------
module dry_wet_latency_crossfader_unit #(
  parameter int unsigned DELAY_DEPTH = 131072,
  parameter int unsigned CHANNELS    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // channel, dry_in, wet_in, block_end, new_latency
  input  logic [1:0]  s_axis_tuser_i,  // cmd
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // audio_out, channel_out, dry_ready
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_addr_i,
  input  logic [0:0]  cfg_data_i
);
  import dwlc_pkg::*;

  logic       asset_q, repl_q;
  logic       q_valid, q_pop;
  item_t      q_item;
  back_stat_t stat;
  logic [23:0] audio;
  logic [2:0]  ch;
  logic        drdy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asset_q <= 1'b0;
      repl_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_ASSET_ACTIVE: asset_q <= cfg_data_i[0];
        REG_REPL_DRY:     repl_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  dwlc_front #(.CHANNELS(CHANNELS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o),
    .in_data_i(s_axis_tdata_i), .in_last_i(s_axis_tlast_i), .in_user_i(s_axis_tuser_i),
    .stat_i(stat), .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  dwlc_back #(
    .DELAY_DEPTH(DELAY_DEPTH), .CHANNELS(CHANNELS)
  ) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .asset_active_i(asset_q), .repl_dry_i(repl_q), .stat_o(stat),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .audio_o(audio), .channel_o(ch), .last_o(m_axis_tlast_o), .dry_ready_o(drdy)
  );

  assign m_axis_tdata_o = {4'd0, drdy, ch, audio};

  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !s_axis_tready_o) else $error("input accepted during clear");
  a_no_out_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !m_axis_tvalid_o) else $error("output during clear");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid && !stat.busy) else $error("queue popped while busy");

endmodule

>>> verif/dry_wet_latency_crossfader_unit_tb.sv
// ----------------------------------------------------------------------------
// dry_wet_latency_crossfader_unit_tb
// Drives sample and command words into the crossfader, mirrors the delay
// ring, wet-mix ramps and latency fade in a local predictor, and checks every
// output word in order. A directed table runs first, then random frames under
// several register settings, idle patterns and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dry_wet_latency_crossfader_unit_tb;
  import dwlc_pkg::*;

  localparam int unsigned DEPTH  = 131072;
  localparam int unsigned NCH    = 8;
  localparam int unsigned FADE   = 128;
  localparam int unsigned WD_MAX = 3000000;

  typedef struct {
    kind_e             kind;
    logic [2:0]        ch;
    logic [23:0]       dry;
    logic [23:0]       wet;
    logic              fe;
    logic              be;
    logic [16:0]       lat;
    bit                typed;
    logic [23:0]       typed_audio;
  } word_t;

  typedef struct packed {
    logic [23:0] audio;
    logic [2:0]  ch;
    logic        last;
    logic        rdy;
  } out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_addr_i = '0;
  logic [0:0]  cfg_data_i = '0;

  dry_wet_latency_crossfader_unit uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic signed [23:0] dry_ring [int unsigned];
  int unsigned wpos, fade_left, cur_lat, prev_lat;
  int unsigned wet_mix [NCH];
  bit          muted, dry_rdy, asset_on, repl_req;

  out_t        exp_words [$];
  int          fails;
  int          tx_idle, rx_idle;
  int          wd_cnt;
  bit          hold_req;
  int          hold_cnt;
  word_t       dir_tbl [$];

  function automatic int unsigned gain_now();
    if (fade_left == 0) return FADE;
    if (fade_left > FADE) return fade_left - FADE;
    return FADE - fade_left;
  endfunction

  task automatic crossfade_step(input word_t w);
    int unsigned g, dly, pos, rpos, tgt, n;
    longint dry, wet, mix, v128, num, mag, q, res;
    bit all_z, all_f;
    out_t o;
    if (w.kind == K_COMMIT) begin
      prev_lat = cur_lat;
      cur_lat = 32'(w.lat);
      fade_left = (prev_lat == cur_lat) ? 0 : 2 * FADE;
      dry_rdy = 0;
      return;
    end
    if (w.kind == K_CLEAR) begin
      prev_lat = cur_lat;
      cur_lat = 0;
      fade_left = (prev_lat == 0) ? 0 : 2 * FADE;
      muted = 1;
      dry_rdy = 0;
      return;
    end
    if (w.kind != K_SAMPLE || w.ch >= NCH) return;
    if (repl_req) muted = 1;
    else dry_rdy = 0;
    g = gain_now();
    dly = (fade_left > FADE) ? prev_lat : cur_lat;
    if (dly >= DEPTH) dly = DEPTH - 1;
    pos = wpos % DEPTH;
    dry_ring[w.ch * DEPTH + pos] = w.dry;
    rpos = (pos >= dly) ? pos - dly : DEPTH + pos - dly;
    dry = dry_ring.exists(w.ch * DEPTH + rpos) ? longint'(dry_ring[w.ch * DEPTH + rpos]) : 0;
    wet = longint'($signed(w.wet));
    tgt = (asset_on && !repl_req) ? MIX_FULL : 0;
    if (wet_mix[w.ch] < tgt) wet_mix[w.ch]++;
    else if (wet_mix[w.ch] > tgt) wet_mix[w.ch]--;
    mix = longint'(wet_mix[w.ch]);
    if (muted || !asset_on) v128 = mix * wet;
    else v128 = dry * 128 + mix * (wet - dry);
    num = v128 * longint'(g);
    mag = (num < 0) ? -num : num;
    q = (mag + 64 * FADE) / (128 * FADE);
    if (q > 8388608) q = 8388608;
    res = (num < 0) ? -q : q;
    if (res > 8388607) res = 8388607;
    if (w.fe) begin
      wpos = pos + 1;
      if (wpos >= DEPTH) wpos = 0;
      if (fade_left > 0) fade_left--;
    end
    if (w.be) begin
      n = 32'(w.ch) + 1;
      if (repl_req && asset_on) begin
        all_z = 1;
        for (int i = 0; i < n; i++) if (wet_mix[i] != 0) all_z = 0;
        dry_rdy = all_z;
      end
      if (muted && !repl_req && asset_on) begin
        all_f = 1;
        for (int i = 0; i < n; i++) if (wet_mix[i] != MIX_FULL) all_f = 0;
        muted = !all_f;
      end
    end
    o.audio = w.typed ? w.typed_audio : res[23:0];
    o.ch = w.ch;
    o.last = w.fe;
    o.rdy = dry_rdy;
    exp_words.push_back(o);
  endtask

  task automatic send_word(input word_t w);
    int gap;
    gap = ($urandom_range(99) < tx_idle) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= w.kind;
    s_axis_tlast_i  <= w.fe;
    s_axis_tdata_i  <= {3'b0, w.lat, w.be, w.wet, w.dry, w.ch};
    do @(posedge clk_i); while (!s_axis_tready_o);
    crossfade_step(w);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_ASSET_ACTIVE) asset_on = val;
    else repl_req = val;
  endtask

  task automatic drain_idle();
    s_axis_tvalid_i <= 1'b0;
    while (exp_words.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic word_t mk(kind_e k, logic [2:0] ch, logic [23:0] d, logic [23:0] wt,
                               bit fe, bit be, logic [16:0] lat, bit typed,
                               logic [23:0] ta);
    word_t w;
    w.kind = k; w.ch = ch; w.dry = d; w.wet = wt; w.fe = fe; w.be = be;
    w.lat = lat; w.typed = typed; w.typed_audio = ta;
    return w;
  endfunction

  function automatic word_t rand_sample(logic [2:0] ch, bit fe, bit be);
    logic [23:0] d, wt;
    case ($urandom_range(9))
      0: d = 24'h7FFFFF;
      1: d = 24'h800000;
      default: d = 24'($urandom);
    endcase
    case ($urandom_range(9))
      0: wt = 24'h7FFFFF;
      1: wt = 24'h800000;
      default: wt = 24'($urandom);
    endcase
    return mk(K_SAMPLE, ch, d, wt, fe, be, 17'($urandom), 1'b0, '0);
  endfunction

  task automatic random_run(input int count);
    int sent, nch, r;
    logic [16:0] lat;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      if (r < 5) begin
        lat = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 12));
        send_word(mk(K_COMMIT, 3'($urandom), 24'($urandom), 24'($urandom),
                     1'($urandom), 1'($urandom), lat, 1'b0, '0));
        sent++;
      end else if (r < 8) begin
        send_word(mk(K_CLEAR, 3'($urandom), 24'($urandom), 24'($urandom),
                     1'($urandom), 1'($urandom), 17'($urandom), 1'b0, '0));
        sent++;
      end else if (r < 11) begin
        send_word(mk(kind_e'(2'd3), 3'($urandom), 24'($urandom), 24'($urandom),
                     1'($urandom), 1'($urandom), 17'($urandom), 1'b0, '0));
      end else if (r < 14) begin
        send_word(rand_sample(3'($urandom_range(NCH - 1)), 1'($urandom), 1'($urandom)));
        sent++;
      end else begin
        nch = ($urandom_range(9) < 7) ? 1 : $urandom_range(1, NCH);
        r = $urandom_range(3);
        for (int c = 0; c < nch; c++) begin
          send_word(rand_sample(3'(c), c == nch - 1, (c == nch - 1) && (r != 0)));
          sent++;
        end
      end
    end
  endtask

  // output side: check and backpressure
  always @(posedge clk_i) begin
    out_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[23:0], m_axis_tdata_o[26:24], m_axis_tlast_o,
             m_axis_tdata_o[27]};
      if (exp_words.size() == 0) begin
        $error("unexpected output word %h", m_axis_tdata_o);
        fails++;
      end else begin
        want = exp_words.pop_front();
        if (got.audio !== want.audio) begin
          $error("audio_out exp %h got %h", want.audio, got.audio); fails++;
        end
        if (got.ch !== want.ch) begin
          $error("channel_out exp %0d got %0d", want.ch, got.ch); fails++;
        end
        if (got.last !== want.last) begin
          $error("frame_last exp %0d got %0d", want.last, got.last); fails++;
        end
        if (got.rdy !== want.rdy) begin
          $error("dry_ready exp %0d got %0d", want.rdy, got.rdy); fails++;
        end
      end
    end
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle);
    end
  end

  // watchdog: cycles without any accepted word (covers the ring clear)
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o))
      wd_cnt <= 0;
    else
      wd_cnt <= wd_cnt + 1;
    if (wd_cnt >= WD_MAX) begin
      $display("dry_wet_latency_crossfader_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    fails = 0; wd_cnt = 0; hold_req = 0; hold_cnt = 0;
    wpos = 0; fade_left = 0; cur_lat = 0; prev_lat = 0;
    foreach (wet_mix[i]) wet_mix[i] = 0;
    muted = 1; dry_rdy = 0; asset_on = 0; repl_req = 0;
    tx_idle = 18; rx_idle = 51;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: mix is zero while the asset is off, so samples come out zero
    dir_tbl.push_back(mk(K_SAMPLE, 3'd0, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b0, 17'd0,
                         1'b1, '0));
    dir_tbl.push_back(mk(K_SAMPLE, 3'd7, 24'h800000, 24'h800000, 1'b1, 1'b1, 17'd0,
                         1'b1, '0));
    dir_tbl.push_back(mk(kind_e'(2'd3), 3'd2, 24'h123456, 24'h654321, 1'b1, 1'b1, 17'd5,
                         1'b0, '0));
    dir_tbl.push_back(mk(K_CLEAR, 3'd0, 24'd0, 24'd0, 1'b0, 1'b0, 17'd0, 1'b0, '0));
    dir_tbl.push_back(mk(K_COMMIT, 3'd0, 24'd0, 24'd0, 1'b0, 1'b0, 17'd3, 1'b0, '0));
    dir_tbl.push_back(mk(K_COMMIT, 3'd0, 24'd0, 24'd0, 1'b0, 1'b0, 17'd3, 1'b0, '0));
    dir_tbl.push_back(mk(K_SAMPLE, 3'd3, 24'h000001, 24'hFFFFFF, 1'b0, 1'b0, 17'd0,
                         1'b1, '0));
    dir_tbl.push_back(mk(K_SAMPLE, 3'd4, 24'h400000, 24'hC00000, 1'b1, 1'b1, 17'd0,
                         1'b1, '0));
    dir_tbl.push_back(mk(K_CLEAR, 3'd5, 24'd0, 24'd0, 1'b1, 1'b1, 17'd0, 1'b0, '0));
    dir_tbl.push_back(mk(K_COMMIT, 3'd0, 24'd0, 24'd0, 1'b0, 1'b0, 17'h1FFFF, 1'b0, '0));
    dir_tbl.push_back(mk(K_SAMPLE, 3'd0, 24'h7FFFFF, 24'h800000, 1'b1, 1'b1, 17'd0,
                         1'b0, '0));
    dir_tbl.push_back(mk(K_CLEAR, 3'd0, 24'd0, 24'd0, 1'b0, 1'b0, 17'd0, 1'b0, '0));
    dir_tbl.push_back(mk(K_SAMPLE, 3'd1, 24'h800000, 24'h7FFFFF, 1'b1, 1'b1, 17'd0,
                         1'b1, '0));
    foreach (dir_tbl[i]) send_word(dir_tbl[i]);
    drain_idle();

    write_reg(REG_ASSET_ACTIVE, 1'b1);
    write_reg(REG_REPL_DRY, 1'b0);
    hold_req = 1;
    random_run(160);
    drain_idle();

    tx_idle = 51; rx_idle = 18;
    write_reg(REG_REPL_DRY, 1'b1);
    random_run(150);
    drain_idle();

    tx_idle = 0; rx_idle = 0;
    write_reg(REG_ASSET_ACTIVE, 1'b0);
    random_run(120);
    drain_idle();

    write_reg(REG_ASSET_ACTIVE, 1'b1);
    write_reg(REG_REPL_DRY, 1'b0);
    random_run(170);
    drain_idle();

    if (fails == 0)
      $display("dry_wet_latency_crossfader_unit_tb OK");
    else
      $display("dry_wet_latency_crossfader_unit_tb NOT OK");
    $finish;
  end

endmodule
